[rtl/core/exception_entry_sequencer_assert.svh]
// assertion macros shared by the checker
`ifndef EXCEPTION_ENTRY_SEQUENCER_ASSERT_SVH
`define EXCEPTION_ENTRY_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define EES_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("exception entry sequencer check failed");

// next-cycle implication, disabled while reset is low
`define EES_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("exception entry sequencer check failed");

`endif

[rtl/core/eeseq_pkg.sv]
package eeseq_pkg;

  localparam int unsigned InDataW  = 200;
  localparam int unsigned OutDataW = 184;
  localparam int unsigned NumSlots = 5;
  localparam int unsigned SlotIdxW = 3;
  localparam int unsigned VbrW     = 32;

  localparam logic [15:0] SrValid = 16'hF71F;
  localparam logic [15:0] SrTrace = 16'hC000;
  localparam int unsigned SrSBit  = 13;
  localparam int unsigned SrMBit  = 12;

  localparam logic [7:0] IackSpurious = 8'h00;
  localparam logic [7:0] IackAuto     = 8'hFF;
  localparam logic [7:0] VecSpurious  = 8'd24;
  localparam logic [7:0] VecIntLo     = 8'd25;
  localparam logic [7:0] VecIntHi     = 8'd31;

  typedef enum logic [1:0] {
    CMD_EXC   = 2'd0,
    CMD_IRQ   = 2'd1,
    CMD_VDATA = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_WR_WORD  = 3'd0,
    KIND_WR_LONG  = 3'd1,
    KIND_VREAD    = 3'd2,
    KIND_ENTERED  = 3'd3,
    KIND_HALTED   = 3'd4,
    KIND_NOT_TAKEN = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    SP_NONE = 2'd0,
    SP_USP  = 2'd1,
    SP_MSP  = 2'd2
  } sp_kind_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  vector;
    logic [15:0] status_reg;
    logic [31:0] cur_pc;
    logic [31:0] next_pc;
    logic [31:0] cur_a7;
    logic [31:0] int_stack_ptr;
    logic [2:0]  pending_level;
    logic [7:0]  iack_vector;
    logic        iack_present;
    logic [31:0] read_data;
    logic        bus_error;
  } item_t;

  typedef struct packed {
    logic        awaiting;
    logic        halted;
    logic [15:0] held_sr;
    logic [31:0] held_a7;
    logic [1:0]  held_sp_kind;
    logic [31:0] held_sp_value;
  } seq_state_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] addr;
    logic [31:0] data;
  } slot_t;

  typedef struct packed {
    logic [SlotIdxW-1:0]      cnt;
    slot_t [NumSlots-1:0]     slot;
    logic [15:0]              new_sr;
    logic [31:0]              new_a7;
    logic [1:0]               sp_kind;
    logic [31:0]              sp_value;
    logic [31:0]              handler_pc;
  } frame_t;

endpackage

[rtl/core/eeseq_decode.sv]
module eeseq_decode import eeseq_pkg::*; (
  input  item_t      item_i,
  input  seq_state_t state_i,
  input  logic [31:0] vbr_i,
  output frame_t     frame_o,
  output seq_state_t state_o
);

  logic [7:0]  vec;
  logic        is_int;
  logic        not_taken;
  logic [15:0] sr_now;
  logic [15:0] nsr;
  logic        fmt2;
  logic [31:0] ret_pc;
  logic [15:0] fword;
  logic [31:0] base;
  logic [31:0] top;
  logic [1:0]  sp_kind;
  logic [31:0] sp_value;
  logic [7:0]  ack;
  slot_t       rest [4];

  // vector and interrupt class
  always_comb begin
    ack       = item_i.iack_present ? item_i.iack_vector : IackAuto;
    not_taken = 1'b0;
    vec       = item_i.vector;
    is_int    = (item_i.vector >= VecIntLo) && (item_i.vector <= VecIntHi);
    sr_now    = item_i.status_reg;
    if (item_i.cmd == CMD_IRQ) begin
      is_int    = 1'b1;
      not_taken = (item_i.pending_level == 3'd0) ||
                  (item_i.pending_level <= item_i.status_reg[10:8]);
      sr_now    = {item_i.status_reg[15:11], item_i.pending_level, item_i.status_reg[7:0]};
      if (ack == IackSpurious) begin
        vec = VecSpurious;
      end else if (ack == IackAuto) begin
        vec = VecSpurious + {5'd0, item_i.pending_level};
      end else begin
        vec = ack;
      end
    end
  end

  // new sr, stack switch and frame layout
  always_comb begin
    nsr = (sr_now | (16'd1 << SrSBit)) & ~SrTrace;
    if (is_int) begin
      nsr[SrMBit] = 1'b0;
    end
    nsr = nsr & SrValid;

    sp_kind  = SP_NONE;
    sp_value = '0;
    base     = item_i.cur_a7;
    if (!item_i.status_reg[SrSBit]) begin
      sp_kind  = SP_USP;
      sp_value = item_i.cur_a7;
      base     = item_i.int_stack_ptr;
    end else if (is_int && item_i.status_reg[SrMBit]) begin
      sp_kind  = SP_MSP;
      sp_value = item_i.cur_a7;
      base     = item_i.int_stack_ptr;
    end

    fmt2 = (vec == 8'd4) || (vec == 8'd6) || (vec == 8'd7) ||
           (vec == 8'd8) || (vec == 8'd10) || (vec == 8'd11);
    ret_pc = ((vec == 8'd6) || (vec == 8'd7)) ? item_i.next_pc : item_i.cur_pc;
    fword  = {2'b00, fmt2, 3'b000, vec, 2'b00};
    top    = fmt2 ? (base - 32'd4) : base;

    rest[0] = '{kind: KIND_WR_WORD, addr: top - 32'd2, data: {16'd0, item_i.status_reg}};
    rest[1] = '{kind: KIND_WR_LONG, addr: top - 32'd6, data: ret_pc};
    rest[2] = '{kind: KIND_WR_WORD, addr: top - 32'd8, data: {16'd0, fword}};
    rest[3] = '{kind: KIND_VREAD, addr: vbr_i + {22'd0, vec, 2'b00}, data: 32'd0};
  end

  always_comb begin
    frame_o = '0;
    state_o = state_i;
    unique case (item_i.cmd)
      CMD_NONE: begin
        frame_o.cnt = '0;
      end
      CMD_EXC, CMD_IRQ: begin
        if (state_i.halted) begin
          frame_o.cnt          = SlotIdxW'(1);
          frame_o.slot[0].kind = KIND_HALTED;
        end else if (not_taken) begin
          frame_o.cnt          = SlotIdxW'(1);
          frame_o.slot[0].kind = KIND_NOT_TAKEN;
        end else begin
          if (fmt2) begin
            frame_o.cnt     = SlotIdxW'(5);
            frame_o.slot[0] = '{kind: KIND_WR_LONG, addr: top, data: item_i.cur_pc};
            frame_o.slot[1] = rest[0];
            frame_o.slot[2] = rest[1];
            frame_o.slot[3] = rest[2];
            frame_o.slot[4] = rest[3];
          end else begin
            frame_o.cnt     = SlotIdxW'(4);
            frame_o.slot[0] = rest[0];
            frame_o.slot[1] = rest[1];
            frame_o.slot[2] = rest[2];
            frame_o.slot[3] = rest[3];
          end
          state_o.awaiting      = 1'b1;
          state_o.held_sr       = nsr;
          state_o.held_a7       = top - 32'd8;
          state_o.held_sp_kind  = sp_kind;
          state_o.held_sp_value = sp_value;
        end
      end
      CMD_VDATA: begin
        if (state_i.halted) begin
          frame_o.cnt          = SlotIdxW'(1);
          frame_o.slot[0].kind = KIND_HALTED;
        end else if (state_i.awaiting) begin
          state_o.awaiting = 1'b0;
          frame_o.cnt      = SlotIdxW'(1);
          if (item_i.bus_error) begin
            state_o.halted       = 1'b1;
            frame_o.slot[0].kind = KIND_HALTED;
          end else begin
            frame_o.slot[0].kind = KIND_ENTERED;
            frame_o.new_sr       = state_i.held_sr;
            frame_o.new_a7       = state_i.held_a7;
            frame_o.sp_kind      = state_i.held_sp_kind;
            frame_o.sp_value     = state_i.held_sp_value;
            frame_o.handler_pc   = item_i.read_data;
          end
        end
      end
      default: begin
        frame_o.cnt = '0;
      end
    endcase
  end

endmodule

[rtl/core/eeseq_emit.sv]
module eeseq_emit import eeseq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  frame_t              frame_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [2:0]          kind_o,
  output logic                last_o,
  output logic [OutDataW-1:0] data_o
);

  frame_t              frame_q;
  logic                busy_q;
  logic [SlotIdxW-1:0] idx_q;
  slot_t               cur;
  logic                fire;

  assign cur     = frame_q.slot[idx_q];
  assign last_o  = (idx_q == frame_q.cnt - SlotIdxW'(1));
  assign valid_o = busy_q;
  assign kind_o  = cur.kind;
  assign fire    = busy_q && ready_i;
  assign free_o  = !busy_q || (fire && last_o);

  // address, write_data, new_sr, new_a7, saved_sp_kind, saved_sp_value, handler_pc
  assign data_o = {6'd0, frame_q.handler_pc, frame_q.sp_value, frame_q.sp_kind,
                   frame_q.new_a7, frame_q.new_sr, cur.data, cur.addr};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= (frame_i.cnt != '0);
      idx_q  <= '0;
    end else if (fire) begin
      if (last_o) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + SlotIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i;
    end
  end

endmodule

[rtl/core/exception_entry_sequencer.sv]
// timing: a request waits in the input register until the result register is free,
// then loads there; the frame streams one result a cycle while m_axis_tready is high
// results: 4 or 5 for an entry, 1 for a halt, not-taken or vector fetch, else none;
// requests with no result pass at one per cycle while the result register is free
// reset: async active low, clears vbr, the pending-entry and halt state and both stages
module exception_entry_sequencer import eeseq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // vbr write port
  input  logic                cfg_we_i,
  input  logic [VbrW-1:0]     cfg_wdata_i,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // vector, status_reg, cur_pc, next_pc, cur_a7, int_stack_ptr, pending_level,
  // iack_vector, iack_present, read_data, bus_error, pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // cmd
  input  logic [1:0]          s_axis_tuser,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // address, write_data, new_sr, new_a7, saved_sp_kind, saved_sp_value,
  // handler_pc, pad
  output logic [OutDataW-1:0] m_axis_tdata,
  // kind
  output logic [2:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  logic [VbrW-1:0] vbr_q;
  item_t           item_q;
  logic            in_vld_q;
  seq_state_t      state_q;
  seq_state_t      state_d;
  frame_t          frame;
  logic            emit_free;
  logic            take;
  logic            accept;

  // the decode stage hands its request to the output side only when the result
  // register is empty or its last result leaves this cycle
  assign take          = in_vld_q && emit_free;
  assign s_axis_tready = !in_vld_q || take;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // vector base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbr_q <= '0;
    end else if (cfg_we_i) begin
      vbr_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (take) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.cmd           <= s_axis_tuser;
      item_q.vector        <= s_axis_tdata[7:0];
      item_q.status_reg    <= s_axis_tdata[23:8];
      item_q.cur_pc        <= s_axis_tdata[55:24];
      item_q.next_pc       <= s_axis_tdata[87:56];
      item_q.cur_a7        <= s_axis_tdata[119:88];
      item_q.int_stack_ptr <= s_axis_tdata[151:120];
      item_q.pending_level <= s_axis_tdata[154:152];
      item_q.iack_vector   <= s_axis_tdata[162:155];
      item_q.iack_present  <= s_axis_tdata[163];
      item_q.read_data     <= s_axis_tdata[195:164];
      item_q.bus_error     <= s_axis_tdata[196];
    end
  end

  // entry state: pending vector fetch, halt, and the entry outcome held for cmd 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (take) begin
      state_q <= state_d;
    end
  end

  // one pass: mask test, vector pick, new sr, stack switch, frame addresses
  eeseq_decode u_decode (
    .item_i  (item_q),
    .state_i (state_q),
    .vbr_i   (vbr_q),
    .frame_o (frame),
    .state_o (state_d)
  );

  // result register, streams the frame one bus request per cycle while m_axis_tready is high
  eeseq_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take),
    .frame_i (frame),
    .free_o  (emit_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .kind_o  (m_axis_tuser),
    .last_o  (m_axis_tlast),
    .data_o  (m_axis_tdata)
  );

endmodule

[rtl/core/eeseq_checker.sv]
`include "exception_entry_sequencer_assert.svh"

module eeseq_checker import eeseq_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [2:0]          m_axis_tuser,
  input logic                m_axis_tlast
);

  // a result offered and not taken is still offered next cycle
  `EES_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // stack frame writes never close a request's results
  `EES_ASSERT_IMP(a_write_not_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == KIND_WR_WORD || m_axis_tuser == KIND_WR_LONG), !m_axis_tlast)

  // vector read, entered, halted and not taken always close the request
  `EES_ASSERT_IMP(a_end_is_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == KIND_VREAD || m_axis_tuser == KIND_ENTERED || m_axis_tuser == KIND_HALTED || m_axis_tuser == KIND_NOT_TAKEN), m_axis_tlast)

  // entry always lands in supervisor mode
  `EES_ASSERT_IMP(a_entered_super, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == KIND_ENTERED), m_axis_tdata[64 + SrSBit])

endmodule

bind exception_entry_sequencer eeseq_checker u_eeseq_checker (.*);
